### hdl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion core.
package rmq_pkg;

	localparam int ENTRY_WIDTH_DEF = 16;
	localparam int EPS_W = 14;
	localparam int TRANS_W = 32;
	localparam int NUM_LANES = 4;
	localparam logic [EPS_W-1:0] EPS_RESET = 14'd1;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

endpackage

### hdl/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to quaternion core.
//
// Input items arrive on the s_axis channel: nine rotation entries in signed
// Q2.14 (at the default entry width) and a Q16.16 translation. Each item
// yields one result item on the m_axis channel: the quaternion, the copied
// translation and, in tuser, the branch that was taken.
// The trace threshold is written through trace_epsilon_wr_en and trace_epsilon_wr_data;
// the user must write it only while no item is in flight, and the block leaves this to the user.
// The pipeline is made of two front stages, the square root pipeline at two root
// bits per stage, the divider pipeline at four quotient bits per stage, and the
// output register.
// One item is accepted in every cycle while the output is free or taken.
// When the receiver stalls, the output register holds its item and the whole
// pipeline freezes; s_axis_tready follows the same enable.
// Reset clears every valid bit and sets the threshold to one LSB.
module rotation_matrix_to_quaternion_core #(
	parameter int ENTRY_WIDTH = rmq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic trace_epsilon_wr_en,
	input  logic [rmq_pkg::EPS_W-1:0] trace_epsilon_wr_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, trans_x, trans_y, trans_z, zero fill
	input  logic [((9*ENTRY_WIDTH+3*rmq_pkg::TRANS_W+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// quat_w, quat_x, quat_y, quat_z, out_trans_x, out_trans_y, out_trans_z, zero fill
	output logic [((4*ENTRY_WIDTH+3*rmq_pkg::TRANS_W+7)/8)*8-1:0] m_axis_tdata,
	// branch_taken
	output logic [1:0] m_axis_tuser
);
	import rmq_pkg::*;

	localparam int EW = ENTRY_WIDTH;
	localparam int FRAC = EW - 2;
	localparam int LW = EW + 1;
	localparam int QW = 2 * EW - 1;
	localparam int OUT_W = ((4*EW+3*TRANS_W+7)/8)*8;
	localparam int SQ_PW = NUM_LANES * LW + NUM_LANES + 2 + 3 * TRANS_W;
	localparam int DV_PW = 2 * NUM_LANES + 2 + 3 * TRANS_W;
	localparam logic [QW-1:0] QLIM = {{(QW-EW){1'b0}}, 1'b1, {(EW-1){1'b0}}};
	localparam logic [QW-1:0] QMAX = QLIM - 1'b1;
	localparam logic [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

	logic               en;
	logic [EPS_W-1:0]   eps_q;
	logic signed [EW-1:0] r_in [9];
	logic [TRANS_W-1:0] trans_in [3];

	logic               fr_v;
	branch_t            fr_br;
	logic [EW:0]        fr_arg;
	logic [NUM_LANES-1:0] fr_neg;
	logic [EW:0]        fr_mag [NUM_LANES];
	logic [TRANS_W-1:0] fr_trans [3];

	logic [2*EW-1:0]    sq_rad;
	logic [SQ_PW-1:0]   sq_pay_in, sq_pay_out;
	logic               sq_v;
	logic [EW-1:0]      sq_root;

	logic [QW-1:0]      dv_dvd [NUM_LANES];
	logic [NUM_LANES-1:0] dv_zero;
	logic [DV_PW-1:0]   dv_pay_in, dv_pay_out;
	logic               dv_v;
	logic [EW-1:0]      dv_root;
	logic [QW-1:0]      dv_quo [NUM_LANES];

	logic [NUM_LANES-1:0] o_neg, o_zero;
	logic [1:0]         o_br;
	logic [EW-1:0]      quat_c [NUM_LANES];

	logic               out_v_q;
	logic [EW-1:0]      quat_q [NUM_LANES];
	logic [TRANS_W-1:0] trans_q [3];
	logic [1:0]         br_q;

	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (trace_epsilon_wr_en) begin
			eps_q <= trace_epsilon_wr_data;
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			r_in[k] = s_axis_tdata[k*EW +: EW];
		end
		for (int k = 0; k < 3; k++) begin
			trans_in[k] = s_axis_tdata[9*EW + k*TRANS_W +: TRANS_W];
		end
	end

	rmq_front #(.EW(EW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.eps      (eps_q),
		.in_v     (s_axis_tvalid),
		.r        (r_in),
		.trans_in (trans_in),
		.out_v    (fr_v),
		.out_br   (fr_br),
		.out_arg  (fr_arg),
		.out_neg  (fr_neg),
		.out_mag  (fr_mag),
		.out_trans(fr_trans)
	);

	assign sq_rad = {1'b0, fr_arg, {FRAC{1'b0}}};
	assign sq_pay_in = {fr_trans[2], fr_trans[1], fr_trans[0], fr_br, fr_neg,
		fr_mag[3], fr_mag[2], fr_mag[1], fr_mag[0]};

	rmq_sqrt #(.EW(EW), .PW(SQ_PW)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (fr_v),
		.in_rad  (sq_rad),
		.in_pay  (sq_pay_in),
		.out_v   (sq_v),
		.out_root(sq_root),
		.out_pay (sq_pay_out)
	);

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			dv_dvd[l]  = {sq_pay_out[l*LW +: LW], {FRAC{1'b0}}};
			dv_zero[l] = sq_pay_out[l*LW +: LW] == '0;
		end
	end
	assign dv_pay_in = {sq_pay_out[SQ_PW-1 -: 3*TRANS_W + 2 + NUM_LANES], dv_zero};

	rmq_div #(.EW(EW), .PW(DV_PW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sq_v),
		.in_root (sq_root),
		.in_dvd  (dv_dvd),
		.in_pay  (dv_pay_in),
		.out_v   (dv_v),
		.out_root(dv_root),
		.out_quo (dv_quo),
		.out_pay (dv_pay_out)
	);

	assign o_zero = dv_pay_out[NUM_LANES-1:0];
	assign o_neg  = dv_pay_out[2*NUM_LANES-1:NUM_LANES];
	assign o_br   = dv_pay_out[2*NUM_LANES +: 2];

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			if (o_br == 2'(l)) begin
				quat_c[l] = EW'(dv_root >> 1);
			end else if (o_zero[l]) begin
				quat_c[l] = '0;
			end else if (o_neg[l]) begin
				quat_c[l] = (dv_quo[l] > QLIM) ? EMIN : -dv_quo[l][EW-1:0];
			end else begin
				quat_c[l] = (dv_quo[l] > QMAX) ? EMAX : dv_quo[l][EW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_q <= quat_c;
			br_q   <= o_br;
			for (int k = 0; k < 3; k++) begin
				trans_q[k] <= dv_pay_out[2*NUM_LANES + 2 + k*TRANS_W +: TRANS_W];
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = br_q;
	assign m_axis_tdata  = OUT_W'({trans_q[2], trans_q[1], trans_q[0],
		quat_q[3], quat_q[2], quat_q[1], quat_q[0]});

endmodule

### hdl/rmq_front.sv
// Front stages: trace, diagonal compares, branch choice, root argument and numerators.
module rmq_front #(
	parameter int EW = rmq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [rmq_pkg::EPS_W-1:0]     eps,
	input  logic                          in_v,
	input  logic signed [EW-1:0]          r [9],
	input  logic [rmq_pkg::TRANS_W-1:0]   trans_in [3],
	output logic                          out_v,
	output rmq_pkg::branch_t              out_br,
	output logic [EW:0]                   out_arg,
	output logic [rmq_pkg::NUM_LANES-1:0] out_neg,
	output logic [EW:0]                   out_mag [rmq_pkg::NUM_LANES],
	output logic [rmq_pkg::TRANS_W-1:0]   out_trans [3]
);
	import rmq_pkg::*;

	localparam int TW = EW + 2;
	localparam int NW = EW + 1;
	localparam int CW = (TW > EPS_W + 1) ? TW : EPS_W + 1;
	localparam logic signed [TW-1:0] ONE = {3'b000, 1'b1, {(EW-2){1'b0}}};

	logic signed [TW-1:0] t_c, ax_c, ay_c, az_c;
	logic signed [NW-1:0] dx_c, dy_c, dz_c, s01_c, s02_c, s12_c;
	logic                 xbig_c, ybig_c;

	logic                 v_s1;
	logic signed [TW-1:0] t_s1, ax_s1, ay_s1, az_s1;
	logic signed [NW-1:0] dx_s1, dy_s1, dz_s1, s01_s1, s02_s1, s12_s1;
	logic                 xbig_s1, ybig_s1;
	logic [TRANS_W-1:0]   trans_s1 [3];

	branch_t              br_c;
	logic signed [TW-1:0] arg_c;
	logic signed [NW-1:0] n_c [NUM_LANES];
	logic [EW:0]          mag_c [NUM_LANES];
	logic [NUM_LANES-1:0] neg_c;

	logic                 v_s2;
	branch_t              br_s2;
	logic [EW:0]          arg_s2;
	logic [NUM_LANES-1:0] neg_s2;
	logic [EW:0]          mag_s2 [NUM_LANES];
	logic [TRANS_W-1:0]   trans_s2 [3];

	always_comb begin
		t_c   = ONE + TW'(r[0]) + TW'(r[4]) + TW'(r[8]);
		ax_c  = ONE + TW'(r[0]) - TW'(r[4]) - TW'(r[8]);
		ay_c  = ONE + TW'(r[4]) - TW'(r[0]) - TW'(r[8]);
		az_c  = ONE + TW'(r[8]) - TW'(r[0]) - TW'(r[4]);
		dx_c  = NW'(r[7]) - NW'(r[5]);
		dy_c  = NW'(r[2]) - NW'(r[6]);
		dz_c  = NW'(r[3]) - NW'(r[1]);
		s01_c = NW'(r[1]) + NW'(r[3]);
		s02_c = NW'(r[2]) + NW'(r[6]);
		s12_c = NW'(r[5]) + NW'(r[7]);
		xbig_c = (r[0] > r[4]) && (r[0] > r[8]);
		ybig_c = r[4] > r[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= t_c;
			ax_s1    <= ax_c;
			ay_s1    <= ay_c;
			az_s1    <= az_c;
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			dz_s1    <= dz_c;
			s01_s1   <= s01_c;
			s02_s1   <= s02_c;
			s12_s1   <= s12_c;
			xbig_s1  <= xbig_c;
			ybig_s1  <= ybig_c;
			trans_s1 <= trans_in;
			br_s2    <= br_c;
			arg_s2   <= arg_c[TW-1] ? '0 : arg_c[EW:0];
			neg_s2   <= neg_c;
			mag_s2   <= mag_c;
			trans_s2 <= trans_s1;
		end
	end

	always_comb begin
		if (signed'(CW'(t_s1)) > signed'(CW'({1'b0, eps}))) begin
			br_c = BR_TRACE;
		end else if (xbig_s1) begin
			br_c = BR_X;
		end else if (ybig_s1) begin
			br_c = BR_Y;
		end else begin
			br_c = BR_Z;
		end
		unique case (br_c)
			BR_TRACE: begin
				arg_c = t_s1;
				n_c[0] = '0; n_c[1] = dx_s1; n_c[2] = dy_s1; n_c[3] = dz_s1;
			end
			BR_X: begin
				arg_c = ax_s1;
				n_c[0] = dx_s1; n_c[1] = '0; n_c[2] = s01_s1; n_c[3] = s02_s1;
			end
			BR_Y: begin
				arg_c = ay_s1;
				n_c[0] = dy_s1; n_c[1] = s01_s1; n_c[2] = '0; n_c[3] = s12_s1;
			end
			default: begin
				arg_c = az_s1;
				n_c[0] = dz_s1; n_c[1] = s02_s1; n_c[2] = s12_s1; n_c[3] = '0;
			end
		endcase
		for (int l = 0; l < NUM_LANES; l++) begin
			neg_c[l] = n_c[l][NW-1];
			mag_c[l] = n_c[l][NW-1] ? NW'(-n_c[l]) : NW'(n_c[l]);
		end
	end

	assign out_v     = v_s2;
	assign out_br    = br_s2;
	assign out_arg   = arg_s2;
	assign out_neg   = neg_s2;
	assign out_mag   = mag_s2;
	assign out_trans = trans_s2;

endmodule

### hdl/rmq_sqrt.sv
// Pipelined restoring square root, two result bits per stage, with a carried side payload.
module rmq_sqrt #(
	parameter int EW = rmq_pkg::ENTRY_WIDTH_DEF,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [2*EW-1:0] in_rad,
	input  logic [PW-1:0]   in_pay,
	output logic            out_v,
	output logic [EW-1:0]   out_root,
	output logic [PW-1:0]   out_pay
);
	localparam int STEPS = 2;
	localparam int NS = (EW + STEPS - 1) / STEPS;
	localparam int RMW = EW + 3;
	localparam int RADW = 2 * EW;

	logic            v_s    [NS];
	logic [RMW-1:0]  rem_s  [NS];
	logic [EW-1:0]   root_s [NS];
	logic [RADW-1:0] rad_s  [NS];
	logic [PW-1:0]   pay_s  [NS];
	logic [RMW-1:0]  rem_n  [NS];
	logic [EW-1:0]   root_n [NS];

	always_comb begin
		logic [RMW-1:0]  rc;
		logic [EW-1:0]   qc;
		logic [RADW-1:0] dc;
		logic [RMW-1:0]  tr;
		int              idx;
		for (int j = 0; j < NS; j++) begin
			if (j == 0) begin
				rc = '0;
				qc = '0;
				dc = in_rad;
			end else begin
				rc = rem_s[j-1];
				qc = root_s[j-1];
				dc = rad_s[j-1];
			end
			for (int k = 0; k < STEPS; k++) begin
				if (j * STEPS + k < EW) begin
					idx = EW - 1 - (j * STEPS + k);
					rc = {rc[RMW-3:0], dc[2*idx +: 2]};
					tr = RMW'({qc, 2'b01});
					if (rc >= tr) begin
						rc = rc - tr;
						qc = {qc[EW-2:0], 1'b1};
					end else begin
						qc = {qc[EW-2:0], 1'b0};
					end
				end
			end
			rem_n[j]  = rc;
			root_n[j] = qc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			for (int j = 0; j < NS; j++) begin
				v_s[j] <= (j == 0) ? in_v : v_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NS; j++) begin
				rem_s[j]  <= rem_n[j];
				root_s[j] <= root_n[j];
				rad_s[j]  <= (j == 0) ? in_rad : rad_s[(j == 0) ? 0 : j-1];
				pay_s[j]  <= (j == 0) ? in_pay : pay_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	assign out_v    = v_s[NS-1];
	assign out_root = root_s[NS-1];
	assign out_pay  = pay_s[NS-1];

endmodule

### hdl/rmq_div.sv
// Pipelined four-lane restoring divider, four quotient bits per stage, with a side payload.
module rmq_div #(
	parameter int EW = rmq_pkg::ENTRY_WIDTH_DEF,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [EW-1:0]   in_root,
	input  logic [2*EW-2:0] in_dvd [rmq_pkg::NUM_LANES],
	input  logic [PW-1:0]   in_pay,
	output logic            out_v,
	output logic [EW-1:0]   out_root,
	output logic [2*EW-2:0] out_quo [rmq_pkg::NUM_LANES],
	output logic [PW-1:0]   out_pay
);
	import rmq_pkg::*;

	localparam int QW = 2 * EW - 1;
	localparam int STEPS = 4;
	localparam int NS = (QW + STEPS - 1) / STEPS;
	localparam int DRW = EW + 2;

	logic          v_s    [NS];
	logic [EW-1:0] root_s [NS];
	logic [PW-1:0] pay_s  [NS];
	logic [QW-1:0] dvd_s  [NS][NUM_LANES];
	logic [QW-1:0] quo_s  [NS][NUM_LANES];
	logic [DRW-1:0] rem_s [NS][NUM_LANES];
	logic [QW-1:0] quo_n  [NS][NUM_LANES];
	logic [DRW-1:0] rem_n [NS][NUM_LANES];

	always_comb begin
		logic [DRW-1:0] rc;
		logic [QW-1:0]  qc;
		logic [QW-1:0]  dc;
		logic [DRW-1:0] dd;
		int             idx;
		for (int j = 0; j < NS; j++) begin
			dd = DRW'({((j == 0) ? in_root : root_s[(j == 0) ? 0 : j-1]), 1'b0});
			for (int l = 0; l < NUM_LANES; l++) begin
				if (j == 0) begin
					rc = '0;
					qc = '0;
					dc = in_dvd[l];
				end else begin
					rc = rem_s[j-1][l];
					qc = quo_s[j-1][l];
					dc = dvd_s[j-1][l];
				end
				for (int k = 0; k < STEPS; k++) begin
					if (j * STEPS + k < QW) begin
						idx = QW - 1 - (j * STEPS + k);
						rc = {rc[DRW-2:0], dc[idx]};
						if (rc >= dd) begin
							rc = rc - dd;
							qc = {qc[QW-2:0], 1'b1};
						end else begin
							qc = {qc[QW-2:0], 1'b0};
						end
					end
				end
				rem_n[j][l] = rc;
				quo_n[j][l] = qc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			for (int j = 0; j < NS; j++) begin
				v_s[j] <= (j == 0) ? in_v : v_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NS; j++) begin
				root_s[j] <= (j == 0) ? in_root : root_s[(j == 0) ? 0 : j-1];
				pay_s[j]  <= (j == 0) ? in_pay : pay_s[(j == 0) ? 0 : j-1];
				for (int l = 0; l < NUM_LANES; l++) begin
					dvd_s[j][l] <= (j == 0) ? in_dvd[l] : dvd_s[(j == 0) ? 0 : j-1][l];
					quo_s[j][l] <= quo_n[j][l];
					rem_s[j][l] <= rem_n[j][l];
				end
			end
		end
	end

	assign out_v    = v_s[NS-1];
	assign out_root = root_s[NS-1];
	assign out_pay  = pay_s[NS-1];
	assign out_quo  = quo_s[NS-1];

endmodule

### hdl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion core, with its bind.
module rmq_checker #(
	parameter int ENTRY_WIDTH = rmq_pkg::ENTRY_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((4*ENTRY_WIDTH+3*rmq_pkg::TRANS_W+7)/8)*8-1:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);
	import rmq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output register");

	a_dominant_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[m_axis_tuser*ENTRY_WIDTH + ENTRY_WIDTH - 1])
		else $error("component of the chosen branch is negative");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_rmq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

### tb/testbench.sv
// Self-checking testbench for the rotation matrix to quaternion core.
module testbench;
	import rmq_pkg::*;

	localparam int EW = ENTRY_WIDTH_DEF;
	localparam int FRAC = EW - 2;
	localparam int IN_W = ((9*EW+3*TRANS_W+7)/8)*8;
	localparam int OUT_W = ((4*EW+3*TRANS_W+7)/8)*8;
	localparam int LATENCY = 19;

	typedef struct packed {
		logic [1:0] branch;
		logic [OUT_W-1:0] data;
	} pose_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic eps_wr_en = 0;
	logic [EPS_W-1:0] eps_wr_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	logic [IN_W-1:0] pose_queue[$];
	pose_result_t quat_expected[$];
	logic [EPS_W-1:0] model_eps = EPS_RESET;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	rotation_matrix_to_quaternion_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.trace_epsilon_wr_en(eps_wr_en),
		.trace_epsilon_wr_data(eps_wr_data),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),
		.m_axis_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_entry(longint v);
		longint hi;
		hi = (64'sd1 <<< (EW-1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic longint root_of(longint a);
		if (a < 0)
			a = 0;
		return longint'(int_sqrt(longint'(a) << FRAC));
	endfunction

	function automatic longint ratio(longint n, longint s);
		longint hi;
		hi = (64'sd1 <<< (EW-1)) - 1;
		if (s == 0)
			return (n > 0) ? hi : ((n < 0) ? -hi - 1 : 0);
		return clamp_entry((n * (64'sd1 <<< FRAC)) / (2 * s));
	endfunction

	function automatic pose_result_t quaternion_of(logic [IN_W-1:0] d);
		longint r[9];
		longint t, s, w, x, y, z, one;
		logic [EW-1:0] q[4];
		branch_t br;
		pose_result_t res;
		for (int i = 0; i < 9; i++)
			r[i] = longint'($signed(d[i*EW +: EW]));
		one = 64'sd1 <<< FRAC;
		t = one + r[0] + r[4] + r[8];
		if (t > longint'(model_eps)) begin
			s = root_of(t);
			w = s >>> 1;
			x = ratio(r[7] - r[5], s);
			y = ratio(r[2] - r[6], s);
			z = ratio(r[3] - r[1], s);
			br = BR_TRACE;
		end else if (r[0] > r[4] && r[0] > r[8]) begin
			s = root_of(one + r[0] - r[4] - r[8]);
			x = s >>> 1;
			y = ratio(r[1] + r[3], s);
			z = ratio(r[2] + r[6], s);
			w = ratio(r[7] - r[5], s);
			br = BR_X;
		end else if (r[4] > r[8]) begin
			s = root_of(one + r[4] - r[0] - r[8]);
			x = ratio(r[1] + r[3], s);
			y = s >>> 1;
			z = ratio(r[5] + r[7], s);
			w = ratio(r[2] - r[6], s);
			br = BR_Y;
		end else begin
			s = root_of(one + r[8] - r[0] - r[4]);
			x = ratio(r[2] + r[6], s);
			y = ratio(r[5] + r[7], s);
			z = s >>> 1;
			w = ratio(r[3] - r[1], s);
			br = BR_Z;
		end
		q[0] = EW'(clamp_entry(w));
		q[1] = EW'(clamp_entry(x));
		q[2] = EW'(clamp_entry(y));
		q[3] = EW'(clamp_entry(z));
		res.data = '0;
		for (int i = 0; i < 4; i++)
			res.data[i*EW +: EW] = q[i];
		res.data[4*EW +: 3*TRANS_W] = d[9*EW +: 3*TRANS_W];
		res.branch = br;
		return res;
	endfunction

	function automatic logic [EW-1:0] rand_entry(int mode);
		case (mode)
			0: return logic'($urandom) ? 16'h7FFF : 16'h8000;
			1: return EW'(int'($urandom_range(0, 2 ** FRAC)) * (logic'($urandom) ? -1 : 1));
			2: return EW'(int'($urandom_range(0, 64)) - 32);
			default: return EW'($urandom);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] make_pose(logic [EW-1:0] e[9]);
		logic [IN_W-1:0] d;
		d = '0;
		for (int i = 0; i < 9; i++)
			d[i*EW +: EW] = e[i];
		d[9*EW +: 3*TRANS_W] = {$urandom, $urandom, $urandom};
		return d;
	endfunction

	function automatic logic [IN_W-1:0] random_pose();
		logic [EW-1:0] e[9];
		int mode;
		int kind;
		mode = $urandom_range(0, 9);
		kind = $urandom_range(0, 5);
		for (int i = 0; i < 9; i++)
			e[i] = rand_entry(mode < 5 ? 1 : (mode < 7 ? 3 : (mode < 8 ? 2 : 0)));
		if (kind == 0) begin
			// Drive the trace near the threshold so the fallback branches are reached.
			e[0] = EW'(-(2 ** FRAC) / 3 + int'($urandom_range(0, 40)) - 20);
			e[4] = EW'(-(2 ** FRAC) / 3 + int'($urandom_range(0, 40)) - 20);
			e[8] = EW'(-(2 ** FRAC) / 3 + int'($urandom_range(0, 40)) - 20);
		end else if (kind == 1) begin
			e[4] = e[0];
			e[8] = logic'($urandom) ? e[0] : e[8];
		end
		return make_pose(e);
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			quat_expected.push_back(quaternion_of(s_tdata));
			if (pose_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
				s_tdata <= pose_queue.pop_front();
			end else begin
				s_tvalid <= 0;
			end
		end else if (!s_tvalid && pose_queue.size() > 0 && arst_n
				&& $urandom_range(1, 100) > send_idle_pct) begin
			s_tvalid <= 1;
			s_tdata <= pose_queue.pop_front();
		end
		m_tready <= $urandom_range(1, 100) > recv_stall_pct;
	end

	always @(posedge clk) begin
		pose_result_t exp_r;
		if (m_tvalid && m_tready) begin
			if (quat_expected.size() == 0) begin
				$display("%0t: unexpected item data=%h branch=%0d", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_r = quat_expected.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_tdata[i*EW +: EW] !== exp_r.data[i*EW +: EW]) begin
						$display("%0t: quat[%0d] expected %h actual %h", $time, i,
							exp_r.data[i*EW +: EW], m_tdata[i*EW +: EW]);
						errors++;
					end
				for (int i = 0; i < 3; i++)
					if (m_tdata[4*EW+i*TRANS_W +: TRANS_W]
							!== exp_r.data[4*EW+i*TRANS_W +: TRANS_W]) begin
						$display("%0t: trans[%0d] expected %h actual %h", $time, i,
							exp_r.data[4*EW+i*TRANS_W +: TRANS_W],
							m_tdata[4*EW+i*TRANS_W +: TRANS_W]);
						errors++;
					end
				if (m_tuser !== exp_r.branch) begin
					$display("%0t: branch expected %0d actual %0d", $time, exp_r.branch, m_tuser);
					errors++;
				end
			end
		end
	end

	task automatic write_eps(logic [EPS_W-1:0] v);
		@(posedge clk);
		eps_wr_en <= 1;
		eps_wr_data <= v;
		@(posedge clk);
		eps_wr_en <= 0;
		model_eps = v;
	endtask

	task automatic drain();
		wait (pose_queue.size() == 0 && !s_tvalid && quat_expected.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		logic [EW-1:0] e[9];
		logic [EPS_W-1:0] eps_set[5];
		int stall_set[4][2];
		eps_set = '{14'd0, 14'd16383, 14'd1, 14'd200, 14'd4000};
		stall_set = '{'{0, 0}, '{82, 0}, '{0, 82}, '{24, 24}};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Identity, the three half-turns, full-scale extremes, traces at and below the reset threshold and zero matrices.
		for (int k = 0; k < 16; k++) begin
			for (int i = 0; i < 9; i++)
				e[i] = 0;
			case (k)
				0: begin e[0] = 16'h4000; e[4] = 16'h4000; e[8] = 16'h4000; end
				1: begin e[0] = 16'h4000; e[4] = 16'hC000; e[8] = 16'hC000; end
				2: begin e[0] = 16'hC000; e[4] = 16'h4000; e[8] = 16'hC000; end
				3: begin e[0] = 16'hC000; e[4] = 16'hC000; e[8] = 16'h4000; end
				4: for (int i = 0; i < 9; i++) e[i] = 16'h7FFF;
				5: for (int i = 0; i < 9; i++) e[i] = 16'h8000;
				6: ;
				7: begin e[0] = 16'h8000; e[4] = 16'h8000; e[8] = 16'h8000;
					e[1] = 16'h7FFF; e[3] = 16'h8000; end
				8: begin e[0] = 16'hC000; e[4] = 16'hC000; e[8] = 16'hC000;
					e[5] = 16'h7FFF; e[7] = 16'h8000; end
				9: begin e[0] = -5461; e[4] = -5461; e[8] = -5462; end
				10: begin e[0] = -5461; e[4] = -5461; e[8] = -5461; end
				11: begin e[0] = 16'hE000; e[4] = 16'hE000; e[8] = 16'hE000;
					e[2] = 16'h8000; e[6] = 16'h8000; end
				12: begin e[0] = 16'h8000; e[4] = 16'h8000; e[8] = 16'h8000; end
				default: for (int i = 0; i < 9; i++) e[i] = rand_entry(0);
			endcase
			pose_queue.push_back(make_pose(e));
		end
		pose_queue.push_back({{3*TRANS_W{1'b1}}, {9*EW{1'b0}}});
		drain();

		for (int ph = 0; ph < 20; ph++) begin
			write_eps(ph < 5 ? eps_set[ph] : EPS_W'($urandom));
			send_idle_pct = stall_set[ph % 4][0];
			recv_stall_pct = stall_set[ph % 4][1];
			for (int n = 0; n < 62; n++)
				pose_queue.push_back(random_pose());
			drain();
		end
		if (errors == 0) begin
			$display("rotation_matrix_to_quaternion_core test passed");
		end else begin
			$display("rotation_matrix_to_quaternion_core test failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("rotation_matrix_to_quaternion_core test failed");
		$finish;
	end

endmodule

### rotation_matrix_to_quaternion_core.f
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion_core.sv
hdl/rmq_checker.sv
tb/testbench.sv
